// ----- hw/rtl/kpc_pkg.sv -----
// Shared types and constants for the key press classifier.
`default_nettype none

package kpc_pkg;

  localparam int unsigned KPC_OUT_W = 8;   // width of the key bit vectors on the ports
  localparam int unsigned KPC_TMR_W = 16;
  localparam int unsigned KPC_TICK_W = 8;
  localparam int unsigned KPC_IDX_W = 3;
  localparam int unsigned KPC_DATA_W = 16;

  localparam logic [KPC_TICK_W-1:0] TICK_MS_RST = 8'd10;
  localparam logic [KPC_TMR_W-1:0] SETTLE_MS_RST = 16'd10;
  localparam logic [KPC_TMR_W-1:0] SHORT_MIN_RST = 16'd20;
  localparam logic [KPC_TMR_W-1:0] LONG_MIN_RST = 16'd300;
  localparam logic [KPC_TMR_W-1:0] REPEAT_MS_RST = 16'd40;

  typedef enum logic [KPC_IDX_W-1:0] {
    REG_TICK_MS   = 3'd0,
    REG_SETTLE_MS = 3'd1,
    REG_SHORT_MIN = 3'd2,
    REG_LONG_MIN  = 3'd3,
    REG_REPEAT_MS = 3'd4
  } kpc_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRESSED = 3'd1,
    PH_LONG    = 3'd2,
    PH_RELEASE = 3'd3,
    PH_SHORT   = 3'd4
  } kpc_phase_t;

  typedef struct packed {
    logic [KPC_TICK_W-1:0] tick_ms;
    logic [KPC_TMR_W-1:0]  settle_ms;
    logic [KPC_TMR_W-1:0]  short_min;
    logic [KPC_TMR_W-1:0]  long_min;
    logic [KPC_TMR_W-1:0]  repeat_ms;
  } kpc_cfg_t;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
    logic repeat_ev;
    logic held;
  } kpc_evt_t;

  // timer + tick, clamped at all ones
  function automatic logic [KPC_TMR_W-1:0] sat_add(input logic [KPC_TMR_W-1:0] a,
                                                   input logic [KPC_TICK_W-1:0] b);
    logic [KPC_TMR_W:0] s;
    s = {1'b0, a} + {{(KPC_TMR_W - KPC_TICK_W + 1){1'b0}}, b};
    return s[KPC_TMR_W] ? {KPC_TMR_W{1'b1}} : s[KPC_TMR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kpc_lane.sv -----
// One key's phase machine with its press, repeat and release timers.
`default_nettype none

module kpc_lane (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic             level,
  input  wire kpc_pkg::kpc_cfg_t cfg,
  output kpc_pkg::kpc_evt_t     evt
);
  import kpc_pkg::*;

  kpc_phase_t phase_r, phase_nxt;
  logic [KPC_TMR_W-1:0] press_r, press_nxt;
  logic [KPC_TMR_W-1:0] rep_r, rep_nxt;
  logic [KPC_TMR_W-1:0] rel_r, rel_nxt;
  logic flag_r, flag_nxt;

  logic [KPC_TMR_W-1:0] press_sum, rep_sum, rel_sum;
  logic long_hit, rep_hit, settled, short_ok;

  assign press_sum = sat_add(press_r, cfg.tick_ms);
  assign rep_sum   = sat_add(rep_r, cfg.tick_ms);
  assign rel_sum   = sat_add(rel_r, cfg.tick_ms);
  assign long_hit  = press_sum >= cfg.long_min;
  assign rep_hit   = rep_sum >= cfg.repeat_ms;
  assign settled   = rel_sum >= cfg.settle_ms;
  assign short_ok  = (press_r >= cfg.short_min) && (press_r < cfg.long_min);

  // next phase
  always_comb begin
    unique case (phase_r)
      PH_PRESSED: begin
        if (!level) phase_nxt = PH_RELEASE;
        else if (long_hit) phase_nxt = PH_LONG;
        else phase_nxt = PH_PRESSED;
      end
      PH_LONG:    phase_nxt = level ? PH_LONG : PH_RELEASE;
      PH_RELEASE: begin
        if (!settled) phase_nxt = PH_RELEASE;
        else phase_nxt = short_ok ? PH_SHORT : PH_IDLE;
      end
      PH_SHORT:   phase_nxt = PH_IDLE;
      default:    phase_nxt = level ? PH_PRESSED : PH_IDLE;
    endcase
  end

  // timers, flag and events
  always_comb begin
    press_nxt = press_r;
    rep_nxt   = rep_r;
    rel_nxt   = rel_r;
    flag_nxt  = flag_r;
    evt       = '0;
    unique case (phase_r)
      PH_PRESSED: begin
        if (level) begin
          press_nxt = press_sum;
          if (long_hit) begin
            flag_nxt    = 1'b1;
            evt.long_ev = 1'b1;
            rep_nxt     = '0;
          end
        end else begin
          rel_nxt = '0;
        end
      end
      PH_LONG: begin
        if (level) begin
          rep_nxt = rep_hit ? '0 : rep_sum;
          evt.repeat_ev = rep_hit;
        end else begin
          press_nxt = '0;
          rel_nxt   = '0;
        end
      end
      PH_RELEASE: begin
        rel_nxt = rel_sum;
        if (settled) begin
          flag_nxt     = 1'b0;
          evt.short_ev = short_ok;
        end
      end
      PH_SHORT: ;
      default: begin
        press_nxt = '0;
        rep_nxt   = '0;
      end
    endcase
    evt.held = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      press_r <= '0;
      rep_r   <= '0;
      rel_r   <= '0;
      flag_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      press_r <= press_nxt;
      rep_r   <= rep_nxt;
      rel_r   <= rel_nxt;
      flag_r  <= flag_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/kpc_merge.sv -----
// Gathers the lane events into port vectors and holds them in the result register.
`default_nettype none

module kpc_merge #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             load,
  input  wire kpc_pkg::kpc_evt_t                evt [NUM_KEYS],
  input  wire logic                             out_stall,
  output logic                                  out_valid,
  output logic [kpc_pkg::KPC_OUT_W-1:0]         out_short_events,
  output logic [kpc_pkg::KPC_OUT_W-1:0]         out_long_events,
  output logic [kpc_pkg::KPC_OUT_W-1:0]         out_repeat_events,
  output logic [kpc_pkg::KPC_OUT_W-1:0]         out_long_held
);
  import kpc_pkg::*;

  logic [KPC_OUT_W-1:0] sh_v, lg_v, rp_v, hd_v;
  logic [KPC_OUT_W-1:0] sh_r, lg_r, rp_r, hd_r;
  logic valid_r, valid_nxt;

  // keys past the port width are dropped; missing keys read as zero
  for (genvar k = 0; k < KPC_OUT_W; k++) begin : g_bit
    if (k < NUM_KEYS) begin : g_key
      assign sh_v[k] = evt[k].short_ev;
      assign lg_v[k] = evt[k].long_ev;
      assign rp_v[k] = evt[k].repeat_ev;
      assign hd_v[k] = evt[k].held;
    end else begin : g_pad
      assign sh_v[k] = 1'b0;
      assign lg_v[k] = 1'b0;
      assign rp_v[k] = 1'b0;
      assign hd_v[k] = 1'b0;
    end
  end

  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r <= sh_v;
      lg_r <= lg_v;
      rp_r <= rp_v;
      hd_r <= hd_v;
    end
  end

  assign out_valid         = valid_r;
  assign out_short_events  = sh_r;
  assign out_long_events   = lg_r;
  assign out_repeat_events = rp_r;
  assign out_long_held     = hd_r;

endmodule

`default_nettype wire

// ----- hw/rtl/key_press_classifier.sv -----
// Top level of the per-key short / long / repeat press classifier.
`default_nettype none

// Each input item is one scan tick with the pressed level of every key. Every
// key has its own lane (phase machine plus saturating 16-bit timers) and all
// lanes step together on the tick, so a new item is taken every cycle while
// in_stall is low; its result shows in the result register in the next cycle.
// Input stall rises only while that register is full and the receiver stalls it.
// The user must write configuration registers through the cfg port while no item
// is in flight (not enforced here); indexes past the last register are ignored.
module key_press_classifier #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [kpc_pkg::KPC_IDX_W-1:0]     cfg_index,
  input  wire logic [kpc_pkg::KPC_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [kpc_pkg::KPC_OUT_W-1:0]     in_key_levels,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [kpc_pkg::KPC_OUT_W-1:0]          out_short_events,
  output logic [kpc_pkg::KPC_OUT_W-1:0]          out_long_events,
  output logic [kpc_pkg::KPC_OUT_W-1:0]          out_repeat_events,
  output logic [kpc_pkg::KPC_OUT_W-1:0]          out_long_held
);
  import kpc_pkg::*;

  kpc_cfg_t cfg_r, cfg_nxt;
  kpc_evt_t evt [NUM_KEYS];
  logic     step;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TICK_MS:   cfg_nxt.tick_ms   = cfg_data[KPC_TICK_W-1:0];
        REG_SETTLE_MS: cfg_nxt.settle_ms = cfg_data;
        REG_SHORT_MIN: cfg_nxt.short_min = cfg_data;
        REG_LONG_MIN:  cfg_nxt.long_min  = cfg_data;
        REG_REPEAT_MS: cfg_nxt.repeat_ms = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_ms   <= TICK_MS_RST;
      cfg_r.settle_ms <= SETTLE_MS_RST;
      cfg_r.short_min <= SHORT_MIN_RST;
      cfg_r.long_min  <= LONG_MIN_RST;
      cfg_r.repeat_ms <= REPEAT_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = out_valid & out_stall;
  assign step     = in_valid & ~in_stall;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    logic lvl;
    if (i < KPC_OUT_W) begin : g_in
      assign lvl = in_key_levels[i];
    end else begin : g_off
      assign lvl = 1'b0;
    end
    kpc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (step),
      .level (lvl),
      .cfg   (cfg_r),
      .evt   (evt[i])
    );
  end

  kpc_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (step),
    .evt               (evt),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_short_events  (out_short_events),
    .out_long_events   (out_long_events),
    .out_repeat_events (out_repeat_events),
    .out_long_held     (out_long_held)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/kpc_checker.sv -----
// Port-level checks for the key press classifier, bound to the top level.
`default_nettype none

module kpc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_short_events,
  input wire logic [7:0] out_long_events,
  input wire logic [7:0] out_repeat_events,
  input wire logic [7:0] out_long_held
);

  // a held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // input only backs up behind a full result register
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in result register");

  // a key cannot finish a short press and declare a long press in one tick
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_short_events & out_long_events) == 8'd0)
    else $error("short and long event on same key");

  // long and repeat events only on keys whose long flag is set
  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_long_events | out_repeat_events) & ~out_long_held) == 8'd0)
    else $error("long or repeat event without long held");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_short_events  (out_short_events),
  .out_long_events   (out_long_events),
  .out_repeat_events (out_repeat_events),
  .out_long_held     (out_long_held)
);

`default_nettype wire

// ----- test/tb_key_press_classifier.sv -----
// Self-checking testbench for key_press_classifier: directed ticks, then random key sequences.
`default_nettype none

module tb_key_press_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import kpc_pkg::*;

  localparam int unsigned NKEYS = KPC_OUT_W;
  // indexes past the last register, which the block must ignore
  localparam logic [KPC_IDX_W-1:0] NO_REG_LO = 3'd5;
  localparam logic [KPC_IDX_W-1:0] NO_REG_HI = 3'd7;

  typedef struct packed {
    logic [7:0] short_ev;
    logic [7:0] long_ev;
    logic [7:0] rep_ev;
    logic [7:0] held;
  } tick_res_t;

  typedef struct packed {
    logic      chk;
    tick_res_t res;
  } known_res_t;

  typedef struct packed {
    logic                  is_reg;
    logic [KPC_IDX_W-1:0]  idx;
    logic [KPC_DATA_W-1:0] val;
    logic [7:0]            lv;
    logic                  chk;
    tick_res_t             res;
  } dir_row_t;

  typedef enum {MIX_NORMAL, MIX_NOISE, MIX_SAT_PRESS, MIX_SAT_HOLD} phase_mix_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [KPC_IDX_W-1:0] cfg_index;
  logic [KPC_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [KPC_OUT_W-1:0] in_key_levels;
  logic out_valid;
  logic out_stall;
  logic [KPC_OUT_W-1:0] out_short_events;
  logic [KPC_OUT_W-1:0] out_long_events;
  logic [KPC_OUT_W-1:0] out_repeat_events;
  logic [KPC_OUT_W-1:0] out_long_held;

  // predictor state
  kpc_cfg_t   cfg_model;
  kpc_phase_t lane_phase [NKEYS];
  logic [15:0] lane_press [NKEYS];
  logic [15:0] lane_repeat [NKEYS];
  logic [15:0] lane_release [NKEYS];
  logic        lane_long [NKEYS];

  tick_res_t  pend_q [$];
  known_res_t typed_q [$];
  dir_row_t   dir_tab [$];

  // random key sequencer
  bit gen_lvl [NKEYS];
  int gen_left [NKEYS];

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int n_short = 0;
  int n_long = 0;
  int n_rep = 0;
  bit quiet = 1'b0;

  key_press_classifier #(.NUM_KEYS(NKEYS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_key_levels(in_key_levels),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_short_events(out_short_events),
    .out_long_events(out_long_events),
    .out_repeat_events(out_repeat_events),
    .out_long_held(out_long_held)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] clamp_add(input logic [15:0] a, input logic [7:0] b);
    int unsigned s;
    s = a + b;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] cap16(input int v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // one scan tick through every key lane
  function automatic tick_res_t classify_tick(input logic [7:0] lv);
    tick_res_t r;
    r = '0;
    for (int k = 0; k < NKEYS; k++) begin
      case (lane_phase[k])
        PH_PRESSED: begin
          if (lv[k]) begin
            lane_press[k] = clamp_add(lane_press[k], cfg_model.tick_ms);
            if (lane_press[k] >= cfg_model.long_min) begin
              lane_long[k] = 1'b1;
              r.long_ev[k] = 1'b1;
              lane_repeat[k] = '0;
              lane_phase[k] = PH_LONG;
            end
          end else begin
            lane_release[k] = '0;
            lane_phase[k] = PH_RELEASE;
          end
        end
        PH_LONG: begin
          if (lv[k]) begin
            lane_repeat[k] = clamp_add(lane_repeat[k], cfg_model.tick_ms);
            if (lane_repeat[k] >= cfg_model.repeat_ms) begin
              lane_repeat[k] = '0;
              r.rep_ev[k] = 1'b1;
            end
          end else begin
            lane_press[k] = '0;
            lane_release[k] = '0;
            lane_phase[k] = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          // level is ignored while the release settles
          lane_release[k] = clamp_add(lane_release[k], cfg_model.tick_ms);
          if (lane_release[k] >= cfg_model.settle_ms) begin
            lane_long[k] = 1'b0;
            if (lane_press[k] >= cfg_model.short_min && lane_press[k] < cfg_model.long_min) begin
              r.short_ev[k] = 1'b1;
              lane_phase[k] = PH_SHORT;
            end else begin
              lane_phase[k] = PH_IDLE;
            end
          end
        end
        PH_SHORT: lane_phase[k] = PH_IDLE;
        default: begin
          lane_press[k] = '0;
          lane_repeat[k] = '0;
          if (lv[k]) lane_phase[k] = PH_PRESSED;
          else lane_phase[k] = PH_IDLE;
        end
      endcase
      r.held[k] = lane_long[k];
    end
    return r;
  endfunction

  function automatic void check_bits(input string what, input logic [7:0] want,
                                     input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic void add_tick(input logic [7:0] lv, input logic chk, input logic [7:0] s,
                                   input logic [7:0] l, input logic [7:0] rp,
                                   input logic [7:0] h);
    dir_row_t row;
    row = '0;
    row.lv = lv;
    row.chk = chk;
    row.res.short_ev = s;
    row.res.long_ev = l;
    row.res.rep_ev = rp;
    row.res.held = h;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_reg(input logic [KPC_IDX_W-1:0] idx, input logic [15:0] val);
    dir_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.val = val;
    dir_tab.push_back(row);
  endfunction

  task automatic write_reg(input logic [KPC_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_TICK_MS:   cfg_model.tick_ms = val[7:0];
      REG_SETTLE_MS: cfg_model.settle_ms = val;
      REG_SHORT_MIN: cfg_model.short_min = val;
      REG_LONG_MIN:  cfg_model.long_min = val;
      REG_REPEAT_MS: cfg_model.repeat_ms = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic send_tick(input logic [7:0] lv, input logic chk, input tick_res_t ex);
    known_res_t c;
    c.chk = chk;
    c.res = ex;
    typed_q.push_back(c);
    in_valid <= 1'b1;
    in_key_levels <= lv;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic sender_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 13)) @(posedge clk);
  endtask

  // block is idle once every result is back; wait for that, then a margin
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pend_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input phase_mix_t mix, input int n_items, input bit allow_idle);
    logic [7:0] lv;
    logic [15:0] tw;
    int t, settle, shortm, longm, rep, d, c;
    wait_drained();
    case (mix)
      MIX_SAT_PRESS: begin
        t = $urandom_range(250, 255);
        settle = $urandom_range(0, 600);
        shortm = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535);
        longm = 65535;
        rep = $urandom_range(0, 3);
      end
      MIX_SAT_HOLD: begin
        t = $urandom_range(250, 255);
        settle = 65535;
        shortm = $urandom_range(0, 600);
        longm = $urandom_range(1, 300);
        rep = 65535;
      end
      default: begin
        t = $urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(1, 255);
        settle = t * $urandom_range(0, 3) + $urandom_range(0, t - 1);
        shortm = t * $urandom_range(0, 4) + $urandom_range(0, t - 1);
        longm = ($urandom_range(0, 9) == 0) ? 0
                : shortm + t * $urandom_range(0, 8) + $urandom_range(0, t - 1);
        rep = ($urandom_range(0, 9) == 0) ? 0 : t * $urandom_range(1, 4) + $urandom_range(0, t - 1);
      end
    endcase
    // upper byte of the tick write is junk that the register must drop
    tw = $urandom;
    tw[7:0] = t[7:0];
    write_reg(REG_TICK_MS, tw);
    write_reg(REG_SETTLE_MS, cap16(settle));
    write_reg(REG_SHORT_MIN, cap16(shortm));
    write_reg(REG_LONG_MIN, cap16(longm));
    write_reg(REG_REPEAT_MS, cap16(rep));

    for (int k = 0; k < NKEYS; k++) begin
      gen_lvl[k] = 1'b0;
      gen_left[k] = $urandom_range(0, 3);
    end
    repeat (n_items) begin
      for (int k = 0; k < NKEYS; k++) begin
        if (gen_left[k] == 0) begin
          gen_lvl[k] = ~gen_lvl[k];
          if (gen_lvl[k]) begin
            c = $urandom_range(0, 9);
            if (c < 4) d = cfg_model.short_min / t + $urandom_range(1, 3);
            else if (c < 7)
              d = cfg_model.long_min / t + $urandom_range(2, 3 * (cfg_model.repeat_ms / t) + 4);
            else d = $urandom_range(1, cfg_model.long_min / t + 3);
          end else begin
            // a few releases are short bounces that may end before the settle time
            if ($urandom_range(0, 4) == 0) d = $urandom_range(1, 2);
            else d = cfg_model.settle_ms / t + $urandom_range(1, 3);
          end
          if (d > 400) d = 400;
          gen_left[k] = d;
        end
        gen_left[k]--;
        lv[k] = gen_lvl[k];
      end
      if (mix == MIX_NOISE) lv = $urandom;
      else if ($urandom_range(0, 99) < 8) lv = lv ^ (8'h01 << $urandom_range(0, 7));
      send_tick(lv, 1'b0, '0);
      if (allow_idle && $urandom_range(0, 99) < 12) sender_gap();
    end
  endtask

  // receiver stall bursts
  initial begin : stall_gen
    int n;
    out_stall = 1'b0;
    forever begin
      n = $urandom_range(1, 20);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 13);
      end else begin
        out_stall <= 1'b0;
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin : scoreboard
    tick_res_t want;
    tick_res_t got;
    known_res_t row;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.short_ev = out_short_events;
        got.long_ev = out_long_events;
        got.rep_ev = out_repeat_events;
        got.held = out_long_held;
        results_seen++;
        if (got.short_ev != 0) n_short++;
        if (got.long_ev != 0) n_long++;
        if (got.rep_ev != 0) n_rep++;
        if (pend_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got %08h", $time, got);
          mismatches++;
        end else begin
          want = pend_q.pop_front();
          check_bits("short_events", want.short_ev, got.short_ev);
          check_bits("long_events", want.long_ev, got.long_ev);
          check_bits("repeat_events", want.rep_ev, got.rep_ev);
          check_bits("long_held", want.held, got.held);
        end
      end
      if (in_valid && !in_stall) begin
        want = classify_tick(in_key_levels);
        row = typed_q.pop_front();
        if (row.chk) want = row.res;
        pend_q.push_back(want);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("%0t: timeout", $time);
    $display("tb_key_press_classifier NOT OK");
    $finish;
  end

  initial begin : main
    int wait_cnt;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_key_levels = '0;

    cfg_model.tick_ms = TICK_MS_RST;
    cfg_model.settle_ms = SETTLE_MS_RST;
    cfg_model.short_min = SHORT_MIN_RST;
    cfg_model.long_min = LONG_MIN_RST;
    cfg_model.repeat_ms = REPEAT_MS_RST;
    for (int k = 0; k < NKEYS; k++) begin
      lane_phase[k] = PH_IDLE;
      lane_press[k] = '0;
      lane_repeat[k] = '0;
      lane_release[k] = '0;
      lane_long[k] = 1'b0;
    end

    // reset defaults: a short press on keys 0-3, bounces on 4-7
    add_tick(8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    add_tick(8'hFF, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);  // first pressed tick adds no time
    add_tick(8'hFF, 1'b0, '0, '0, '0, '0);
    add_tick(8'h0F, 1'b0, '0, '0, '0, '0);
    add_tick(8'h0F, 1'b0, '0, '0, '0, '0);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    // all thresholds zero: long at once, a repeat every held tick
    add_reg(REG_LONG_MIN, 16'h0000);
    add_reg(REG_REPEAT_MS, 16'h0000);
    add_reg(REG_SHORT_MIN, 16'h0000);
    add_reg(REG_SETTLE_MS, 16'h0000);
    add_reg(REG_TICK_MS, 16'hFF01);
    add_reg(NO_REG_LO, 16'hFFFF);
    add_reg(NO_REG_HI, 16'h0000);
    add_tick(8'h3C, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    add_tick(8'h3C, 1'b1, 8'h00, 8'h3C, 8'h00, 8'h3C);
    add_tick(8'h3C, 1'b1, 8'h00, 8'h00, 8'h3C, 8'h3C);
    add_tick(8'h0C, 1'b1, 8'h00, 8'h00, 8'h0C, 8'h3C);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    // zero tick freezes the timers mid press and mid release
    add_reg(REG_TICK_MS, 16'h0000);
    add_reg(REG_LONG_MIN, 16'd300);
    add_reg(REG_SETTLE_MS, 16'd10);
    add_tick(8'h81, 1'b0, '0, '0, '0, '0);
    add_tick(8'h81, 1'b0, '0, '0, '0, '0);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    add_reg(REG_TICK_MS, 16'h5AFF);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    // long press settling with a zero short threshold still gives a short
    add_reg(REG_LONG_MIN, 16'd1);
    add_tick(8'h40, 1'b0, '0, '0, '0, '0);
    add_tick(8'h40, 1'b0, '0, '0, '0, '0);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);
    add_tick(8'h00, 1'b0, '0, '0, '0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        wait_drained();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_tick(dir_tab[i].lv, dir_tab[i].chk, dir_tab[i].res);
      end
    end

    for (int p = 0; p < 4; p++) run_phase(MIX_NORMAL, 40, p != 2);
    run_phase(MIX_NOISE, 30, 1'b1);
    run_phase(MIX_SAT_PRESS, 270, 1'b1);
    run_phase(MIX_SAT_HOLD, 270, 1'b1);
    run_phase(MIX_NORMAL, 40, 1'b1);
    quiet = 1'b1;
    run_phase(MIX_NORMAL, 50, 1'b0);

    in_valid <= 1'b0;
    for (wait_cnt = 0; wait_cnt < 5000 && pend_q.size() != 0; wait_cnt++) @(posedge clk);
    repeat (5) @(posedge clk);
    if (pend_q.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 pending, got %0d",
               $time, pend_q.size(), pend_q.size());
      mismatches += pend_q.size();
    end

    $display("%0d scan ticks sent, %0d results checked, %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("results carrying short: %0d, long: %0d, repeat: %0d; mismatches: %0d",
             n_short, n_long, n_rep, mismatches);
    if (mismatches == 0) $display("tb_key_press_classifier OK");
    else $display("tb_key_press_classifier NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
